/* rtl/core/bba_pkg.sv */
`timescale 1ns / 1ps

package bba_pkg;

   localparam int REGION_BYTES    = 65536;
   localparam int MIN_BLOCK_BYTES = 64;
   localparam int DATA_OFFSET     = 16;
   localparam int HEADER_BYTES    = 32;

   localparam int SLOTS     = REGION_BYTES / MIN_BLOCK_BYTES;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int MIN_SHIFT = $clog2(MIN_BLOCK_BYTES);
   localparam int CODE_W    = 4;
   localparam int FULL_CODE = $clog2(SLOTS);
   localparam int WORD_W    = CODE_W + 1;
   localparam int IDX_W     = 2 ** CODE_W + 1;
   localparam int ADDR_W    = IDX_W + MIN_SHIFT;
   localparam int REQ_W     = 16;
   localparam int OFF_W     = 16;
   localparam int SUM_W     = REQ_W + 2;
   localparam int NEED_W    = MIN_SHIFT + 2 ** CODE_W + 1;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_F_RDB,
      ST_F_GOTB,
      ST_F_CHK,
      ST_F_GOTU,
      ST_SPLIT,
      ST_SPLIT_R,
      ST_M_START,
      ST_M_RDB,
      ST_M_GOTB,
      ST_M_CHK,
      ST_M_GOTU,
      ST_M_END,
      ST_R_RD,
      ST_R_GOT,
      ST_RESP
   } state_type;

   typedef enum logic {
      FUNC_ALLOC   = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   function automatic logic [IDX_W-1:0] span_of(input logic [CODE_W-1:0] code);
      return IDX_W'(1) << code;
   endfunction

endpackage

/* rtl/core/bba_if.sv */
`timescale 1ns / 1ps

interface bba_req_if;
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic [bba_pkg::REQ_W-1:0] request_bytes;
   logic [bba_pkg::OFF_W-1:0] release_offset;

   modport source (output valid, output func, output request_bytes,
                   output release_offset, input ready);
   modport sink   (input valid, input func, input request_bytes,
                   input release_offset, output ready);
endinterface

interface bba_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     granted;
   logic [bba_pkg::OFF_W-1:0] data_offset;

   modport source (output valid, output granted, output data_offset, input ready);
   modport sink   (input valid, input granted, input data_offset, output ready);
endinterface

/* rtl/core/bba_ram.sv */
`timescale 1ns / 1ps

module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

/* rtl/core/buddy_block_allocator.sv */
`timescale 1ns / 1ps

// Buddy allocator over a 64 KiB region kept as a 1024-entry header memory, one
// {free, size code} word per 64-byte slot. One request is handled at a time and
// req_ch is ready only while the sequencer is idle; a finished result may still
// wait on rsp_ch while the next request is taken. The work is paced by the single
// read port of the header memory: release walks the block list block by block;
// allocate scans the blocks, halves the chosen block down to the needed size,
// and when nothing fits runs merge passes over buddy block pairs before
// scanning once more. A zero request goes straight to the response. After
// reset, the init state writes the full-region header at slot 0 before the
// first request is taken.

module buddy_block_allocator (
   input  logic      clock,
   input  logic      reset,
   bba_req_if.sink   req_ch,
   bba_rsp_if.source rsp_ch
);

   import bba_pkg::*;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    b_ff, b_in;
   logic [IDX_W-1:0]    u_ff, u_in;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [CODE_W-1:0]   cb_ff, cb_in;
   logic                fb_ff, fb_in;
   logic [CODE_W-1:0]   sc_ff, sc_in;
   logic [CODE_W-1:0]   nc_ff, nc_in;
   logic [SLOT_W-1:0]   best_ff, best_in;
   logic [CODE_W-1:0]   best_code_ff, best_code_in;
   logic                have_ff, have_in;
   logic                pass_ff, pass_in;
   logic                none_ff, none_in;
   logic [OFF_W-1:0]    rel_ff, rel_in;
   logic                res_grant_ff, res_grant_in;
   logic [OFF_W-1:0]    res_off_ff, res_off_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_grant_ff, rsp_grant_in;
   logic [OFF_W-1:0]    rsp_off_ff, rsp_off_in;

   logic                mem_we;
   logic [SLOT_W-1:0]   mem_waddr;
   logic [WORD_W-1:0]   mem_wdata;
   logic [SLOT_W-1:0]   mem_raddr;
   logic [WORD_W-1:0]   mem_rdata;
   logic [CODE_W-1:0]   rd_code;
   logic                rd_free;
   logic [CODE_W-1:0]   need_code;
   logic [SUM_W-1:0]    sum_raw;
   logic [SUM_W-1:0]    sum_rnd;

   bba_ram #(
      .WIDTH(WORD_W),
      .DEPTH(SLOTS)
   ) u_hdr_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   assign rd_code = mem_rdata[CODE_W-1:0];
   assign rd_free = mem_rdata[CODE_W];

   // request plus header, rounded to the data alignment, then to a block size code
   always_comb begin
      sum_raw   = SUM_W'(req_ch.request_bytes) + SUM_W'(HEADER_BYTES);
      sum_rnd   = (sum_raw + SUM_W'(DATA_OFFSET - 1)) & ~SUM_W'(DATA_OFFSET - 1);
      need_code = '1;
      for (int k = 2 ** CODE_W - 1; k >= 0; k--) begin
         if ((NEED_W'(MIN_BLOCK_BYTES) << k) >= NEED_W'(sum_rnd)) begin
            need_code = CODE_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b_ff         <= b_in;
      u_ff         <= u_in;
      i_ff         <= i_in;
      cb_ff        <= cb_in;
      fb_ff        <= fb_in;
      sc_ff        <= sc_in;
      nc_ff        <= nc_in;
      best_ff      <= best_in;
      best_code_ff <= best_code_in;
      have_ff      <= have_in;
      pass_ff      <= pass_in;
      none_ff      <= none_in;
      rel_ff       <= rel_in;
      res_grant_ff <= res_grant_in;
      res_off_ff   <= res_off_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_off_ff   <= rsp_off_in;
   end

   always_comb begin
      logic              have_v;
      logic [SLOT_W-1:0] best_v;
      logic [CODE_W-1:0] bcode_v;
      logic [CODE_W-1:0] code_v;
      logic [IDX_W-1:0]  idx_v;

      have_v  = have_ff;
      best_v  = best_ff;
      bcode_v = best_code_ff;
      code_v  = '0;
      idx_v   = '0;

      state_in     = state_ff;
      b_in         = b_ff;
      u_in         = u_ff;
      i_in         = i_ff;
      cb_in        = cb_ff;
      fb_in        = fb_ff;
      sc_in        = sc_ff;
      nc_in        = nc_ff;
      best_in      = best_ff;
      best_code_in = best_code_ff;
      have_in      = have_ff;
      pass_in      = pass_ff;
      none_in      = none_ff;
      rel_in       = rel_ff;
      res_grant_in = res_grant_ff;
      res_off_in   = res_off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_grant_in = rsp_grant_ff;
      rsp_off_in   = rsp_off_ff;

      mem_we    = 1'b0;
      mem_waddr = b_ff[SLOT_W-1:0];
      mem_wdata = '0;
      mem_raddr = b_ff[SLOT_W-1:0];

      req_ch.ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {1'b1, CODE_W'(FULL_CODE)};
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               rel_in       = req_ch.release_offset;
               nc_in        = need_code;
               b_in         = '0;
               have_in      = 1'b0;
               pass_in      = 1'b0;
               res_grant_in = 1'b0;
               res_off_in   = '0;
               if (req_ch.func == FUNC_RELEASE) begin
                  state_in = ST_R_RD;
               end else if (req_ch.request_bytes == '0) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_F_RDB;
               end
            end
         end
         ST_F_RDB: begin
            mem_raddr = b_ff[SLOT_W-1:0];
            state_in  = ST_F_GOTB;
         end
         ST_F_GOTB: begin
            cb_in = rd_code;
            fb_in = rd_free;
            u_in  = b_ff + span_of(rd_code);
            if ((b_ff + span_of(rd_code)) == IDX_W'(SLOTS) && rd_free) begin
               i_in     = '0;
               sc_in    = rd_code;
               state_in = ST_SPLIT;
            end else begin
               state_in = ST_F_CHK;
            end
         end
         ST_F_CHK: begin
            mem_raddr = u_ff[SLOT_W-1:0];
            if (b_ff < IDX_W'(SLOTS) && u_ff < IDX_W'(SLOTS)) begin
               state_in = ST_F_GOTU;
            end else if (have_ff) begin
               i_in     = IDX_W'(best_ff);
               sc_in    = best_code_ff;
               state_in = ST_SPLIT;
            end else if (!pass_ff) begin
               pass_in  = 1'b1;
               state_in = ST_M_START;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_F_GOTU: begin
            if (fb_ff && nc_ff <= cb_ff && (!have_v || cb_ff <= bcode_v)) begin
               best_v  = b_ff[SLOT_W-1:0];
               bcode_v = cb_ff;
               have_v  = 1'b1;
            end
            if (rd_free && nc_ff <= rd_code && (!have_v || rd_code < bcode_v)) begin
               best_v  = u_ff[SLOT_W-1:0];
               bcode_v = rd_code;
               have_v  = 1'b1;
            end
            best_in      = best_v;
            best_code_in = bcode_v;
            have_in      = have_v;
            b_in         = u_ff;
            cb_in        = rd_code;
            fb_in        = rd_free;
            u_in         = u_ff + span_of(rd_code);
            state_in     = ST_F_CHK;
         end
         ST_SPLIT: begin
            mem_waddr = i_ff[SLOT_W-1:0];
            if (sc_ff > nc_ff) begin
               code_v    = sc_ff - CODE_W'(1);
               mem_we    = 1'b1;
               mem_wdata = {1'b1, code_v};
               sc_in     = code_v;
               i_in      = i_ff + span_of(code_v);
               state_in  = ST_SPLIT_R;
            end else if (sc_ff == nc_ff) begin
               mem_we       = 1'b1;
               mem_wdata    = {1'b0, sc_ff};
               res_grant_in = 1'b1;
               res_off_in   = OFF_W'({i_ff, {MIN_SHIFT{1'b0}}} + ADDR_W'(DATA_OFFSET));
               state_in     = ST_RESP;
            end else if (!pass_ff) begin
               pass_in  = 1'b1;
               state_in = ST_M_START;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SPLIT_R: begin
            mem_waddr = i_ff[SLOT_W-1:0];
            if (i_ff >= IDX_W'(SLOTS)) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = ST_M_START;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               mem_we    = 1'b1;
               mem_wdata = {1'b1, sc_ff};
               state_in  = ST_SPLIT;
            end
         end
         ST_M_START: begin
            b_in     = '0;
            none_in  = 1'b1;
            state_in = ST_M_RDB;
         end
         ST_M_RDB: begin
            mem_raddr = b_ff[SLOT_W-1:0];
            if (b_ff < IDX_W'(SLOTS)) begin
               state_in = ST_M_GOTB;
            end else begin
               state_in = ST_M_END;
            end
         end
         ST_M_GOTB: begin
            cb_in    = rd_code;
            fb_in    = rd_free;
            u_in     = b_ff + span_of(rd_code);
            state_in = ST_M_CHK;
         end
         ST_M_CHK: begin
            mem_raddr = u_ff[SLOT_W-1:0];
            if (u_ff < IDX_W'(SLOTS)) begin
               state_in = ST_M_GOTU;
            end else begin
               state_in = ST_M_END;
            end
         end
         ST_M_GOTU: begin
            if (fb_ff && rd_free && cb_ff == rd_code) begin
               code_v    = cb_ff + CODE_W'(1);
               idx_v     = b_ff + span_of(code_v);
               mem_we    = 1'b1;
               mem_waddr = b_ff[SLOT_W-1:0];
               mem_wdata = {1'b1, code_v};
               b_in      = idx_v;
               if (idx_v < IDX_W'(SLOTS)) begin
                  none_in = 1'b0;
               end
               state_in = ST_M_RDB;
            end else if (cb_ff < rd_code) begin
               b_in     = u_ff;
               cb_in    = rd_code;
               fb_in    = rd_free;
               u_in     = u_ff + span_of(rd_code);
               state_in = ST_M_CHK;
            end else begin
               b_in     = u_ff + span_of(rd_code);
               state_in = ST_M_RDB;
            end
         end
         ST_M_END: begin
            if (none_ff) begin
               b_in     = '0;
               have_in  = 1'b0;
               state_in = ST_F_RDB;
            end else begin
               state_in = ST_M_START;
            end
         end
         ST_R_RD: begin
            mem_raddr = b_ff[SLOT_W-1:0];
            if (b_ff < IDX_W'(SLOTS)) begin
               state_in = ST_R_GOT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_R_GOT: begin
            if (({b_ff, {MIN_SHIFT{1'b0}}} + ADDR_W'(DATA_OFFSET)) == ADDR_W'(rel_ff)) begin
               mem_we       = 1'b1;
               mem_waddr    = b_ff[SLOT_W-1:0];
               mem_wdata    = {1'b1, rd_code};
               res_grant_in = 1'b1;
               res_off_in   = rel_ff;
               state_in     = ST_RESP;
            end else begin
               b_in     = b_ff + span_of(rd_code);
               state_in = ST_R_RD;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_grant_in = res_grant_ff;
               rsp_off_in   = res_off_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.granted     = rsp_grant_ff;
   assign rsp_ch.data_offset = rsp_off_ff;

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while a request is in flight");

   a_result_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside the response step");

   a_fail_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.granted |-> rsp_ch.data_offset == '0)
      else $error("failed result carries an offset");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE || state_ff == ST_RESP |-> !mem_we)
      else $error("header write while idle");

endmodule
